// ===== hdl/rsd_pkg.sv =====
// Shared types, constants and color expansion for the sprite pixel decoder.
`default_nettype none

package rsd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 2;
	localparam int COORD_W = 10;
	localparam int ARGB_W  = 32;

	localparam int CFG_WIDTH_RST  = 1024;
	localparam int CFG_HEIGHT_RST = 1024;

	localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH        = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT       = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RED_TO_TRANSPARENT = 2'd2;

	localparam logic [BYTE_W-1:0] CMD_SKIP  = 8'hFF;
	localparam logic [BYTE_W-1:0] CMD_EMPTY = 8'h00;
	localparam logic [15:0]       KEY_COLOR = 16'hF81F;
	localparam logic [ARGB_W-1:0] PURE_RED  = 32'hFFFF0000;
	localparam logic [ARGB_W-1:0] SHADOW    = 32'h66000000;
	localparam logic [7:0]        OPAQUE    = 8'hFF;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_SKIP,
		PH_LO,
		PH_HI
	} phase_t;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic load_count;
		logic load_low;
		logic pixel;
		logic div_start;
		logic div_step;
		logic div_finish;
	} cmd_t;

	typedef struct packed {
		logic last_pixel;
		logic div_last;
		logic out_stall;
	} status_t;

	function automatic logic [ARGB_W-1:0] expand(input logic [15:0] c, input logic rtt);
		logic [ARGB_W-1:0] v;
		v = {OPAQUE, c[14:10], c[14:12], c[9:5], 1'b0, c[9:8], c[4:0], c[4:2]};
		if (v == PURE_RED && rtt) begin
			v = SHADOW;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rsd_if.sv =====
// Channel interfaces: coded byte input, pixel output and register write.
`default_nettype none

interface rsd_byte_if;
	logic                         valid;
	logic                         ready;
	logic [rsd_pkg::BYTE_W-1:0]   stream_byte;
	logic                         image_start;
	modport source(output valid, output stream_byte, output image_start, input ready);
	modport sink(input valid, input stream_byte, input image_start, output ready);
endinterface

interface rsd_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [rsd_pkg::COORD_W-1:0]  pixel_x;
	logic [rsd_pkg::COORD_W-1:0]  pixel_y;
	logic [rsd_pkg::ARGB_W-1:0]   argb;
	modport source(output valid, output pixel_x, output pixel_y, output argb, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, input argb, output ready);
endinterface

interface rsd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rsd_pkg::CIDX_W-1:0]   index;
	logic [rsd_pkg::CFG_W-1:0]    data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rsd_ctrl.sv =====
// Parser and sequencing state machine of the sprite pixel decoder.
`default_nettype none

module rsd_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [rsd_pkg::BYTE_W-1:0] stream_byte,
	input  wire logic                       image_start,
	input  wire rsd_pkg::status_t           status,
	output rsd_pkg::cmd_t                   cmd
);

	rsd_pkg::state_t state_q, state_d;
	rsd_pkg::phase_t phase_q, phase_d;
	rsd_pkg::phase_t cur_ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsd_pkg::ST_ACCEPT;
			phase_q <= rsd_pkg::PH_CMD;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		cmd      = '0;
		in_ready = 1'b0;
		cur_ph   = image_start ? rsd_pkg::PH_CMD : phase_q;
		unique case (state_q)
			rsd_pkg::ST_ACCEPT: begin
				in_ready = !(phase_q == rsd_pkg::PH_HI && status.out_stall);
				if (in_valid && in_ready) begin
					cmd.clear = image_start;
					unique case (cur_ph)
						rsd_pkg::PH_CMD: begin
							if (stream_byte == rsd_pkg::CMD_SKIP) begin
								phase_d = rsd_pkg::PH_SKIP;
							end else if (stream_byte != rsd_pkg::CMD_EMPTY) begin
								cmd.load_count = 1'b1;
								phase_d        = rsd_pkg::PH_LO;
							end else begin
								phase_d = rsd_pkg::PH_CMD;
							end
						end
						rsd_pkg::PH_SKIP: begin
							cmd.div_start = 1'b1;
							phase_d       = rsd_pkg::PH_CMD;
							state_d       = rsd_pkg::ST_DIV;
						end
						rsd_pkg::PH_LO: begin
							cmd.load_low = 1'b1;
							phase_d      = rsd_pkg::PH_HI;
						end
						rsd_pkg::PH_HI: begin
							cmd.pixel = 1'b1;
							phase_d   = status.last_pixel ? rsd_pkg::PH_CMD : rsd_pkg::PH_LO;
						end
						default: phase_d = rsd_pkg::PH_CMD;
					endcase
				end
			end
			rsd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = rsd_pkg::ST_FINISH;
				end
			end
			rsd_pkg::ST_FINISH: begin
				cmd.div_finish = 1'b1;
				state_d        = rsd_pkg::ST_ACCEPT;
			end
			default: state_d = rsd_pkg::ST_ACCEPT;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/rsd_dp.sv =====
// Datapath: registers, position tracking, skip divider and pixel output register.
`default_nettype none

module rsd_dp #(
	parameter int MAX_WIDTH  = rsd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rsd_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire logic [rsd_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [rsd_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic [rsd_pkg::BYTE_W-1:0]  stream_byte,
	input  wire rsd_pkg::cmd_t               cmd,
	input  wire logic                        out_ready,
	output rsd_pkg::status_t                 status,
	output logic                             out_valid,
	output logic [rsd_pkg::COORD_W-1:0]      pixel_x,
	output logic [rsd_pkg::COORD_W-1:0]      pixel_y,
	output logic [rsd_pkg::ARGB_W-1:0]       argb
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW_W  = $clog2(MAX_WIDTH + 1);
	localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W = $clog2(MAX_WIDTH + 255);
	localparam int REM_W = EW_W + 1;
	localparam int CNT_W = $clog2(POS_W);
	localparam int CLW   = (EW_W > rsd_pkg::CFG_W) ? EW_W : rsd_pkg::CFG_W;
	localparam int CLH   = (EH_W > rsd_pkg::CFG_W) ? EH_W : rsd_pkg::CFG_W;
	localparam int CW    = (POS_W > EH_W) ? POS_W : EH_W;
	localparam int RST_W = (MAX_WIDTH < rsd_pkg::CFG_WIDTH_RST) ? MAX_WIDTH
		: rsd_pkg::CFG_WIDTH_RST;
	localparam int RST_H = (MAX_HEIGHT < rsd_pkg::CFG_HEIGHT_RST) ? MAX_HEIGHT
		: rsd_pkg::CFG_HEIGHT_RST;

	logic [EW_W-1:0]           eff_w_q;
	logic [EH_W-1:0]           eff_h_q;
	logic                      rtt_q;
	logic [rsd_pkg::BYTE_W-1:0] pixels_left_q;
	logic [rsd_pkg::BYTE_W-1:0] low_q;
	logic [COL_W-1:0]          column_q;
	logic [EH_W-1:0]           row_q;
	logic                      out_valid_q;
	logic [POS_W-1:0]          num_q;
	logic [REM_W-1:0]          rem_q;
	logic [CNT_W-1:0]          cnt_q;

	logic [15:0]               color;
	logic                      emit;
	logic [EW_W-1:0]           col_inc;
	logic [EH_W:0]             row_inc;
	logic [EH_W-1:0]           row_step;
	logic [REM_W-1:0]          trial;
	logic                      trial_ge;
	logic                      skip_sat;
	logic [EH_W-1:0]           row_skip;

	assign color    = {stream_byte, low_q};
	assign emit     = color != rsd_pkg::KEY_COLOR && EW_W'(column_q) < eff_w_q
		&& row_q < eff_h_q;
	assign col_inc  = EW_W'(column_q) + EW_W'(1);
	assign row_inc  = (EH_W + 1)'(row_q) + (EH_W + 1)'(1);
	assign row_step = (row_inc >= (EH_W + 1)'(eff_h_q)) ? eff_h_q : row_inc[EH_W-1:0];

	assign trial    = {rem_q[REM_W-2:0], num_q[POS_W-1]};
	assign trial_ge = trial >= REM_W'(eff_w_q);

	assign skip_sat = row_q >= eff_h_q || CW'(num_q) >= CW'(eff_h_q) - CW'(row_q);
	assign row_skip = skip_sat ? eff_h_q : row_q + EH_W'(num_q);

	assign status.last_pixel = pixels_left_q == rsd_pkg::BYTE_W'(1);
	assign status.div_last   = cnt_q == CNT_W'(POS_W - 1);
	assign status.out_stall  = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= EW_W'(RST_W);
			eff_h_q <= EH_W'(RST_H);
			rtt_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rsd_pkg::CFG_IMAGE_WIDTH: begin
					if (cfg_data == '0) begin
						eff_w_q <= EW_W'(1);
					end else if (CLW'(cfg_data) > CLW'(MAX_WIDTH)) begin
						eff_w_q <= EW_W'(MAX_WIDTH);
					end else begin
						eff_w_q <= EW_W'(cfg_data);
					end
				end
				rsd_pkg::CFG_IMAGE_HEIGHT: begin
					if (CLH'(cfg_data) > CLH'(MAX_HEIGHT)) begin
						eff_h_q <= EH_W'(MAX_HEIGHT);
					end else begin
						eff_h_q <= EH_W'(cfg_data);
					end
				end
				rsd_pkg::CFG_RED_TO_TRANSPARENT: rtt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
			low_q         <= '0;
			column_q      <= '0;
			row_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.clear) begin
				low_q    <= '0;
				column_q <= '0;
				row_q    <= '0;
			end
			if (cmd.load_count) begin
				pixels_left_q <= stream_byte;
			end else if (cmd.clear) begin
				pixels_left_q <= '0;
			end else if (cmd.pixel) begin
				pixels_left_q <= pixels_left_q - rsd_pkg::BYTE_W'(1);
			end
			if (cmd.load_low) begin
				low_q <= stream_byte;
			end
			if (cmd.pixel) begin
				if (col_inc >= eff_w_q) begin
					column_q <= '0;
					row_q    <= row_step;
				end else begin
					column_q <= col_inc[COL_W-1:0];
				end
			end
			if (cmd.div_finish) begin
				column_q <= rem_q[COL_W-1:0];
				row_q    <= row_skip;
			end
			if (cmd.pixel && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= POS_W'(column_q) + POS_W'(stream_byte);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial - REM_W'(eff_w_q) : trial;
			num_q <= {num_q[POS_W-2:0], trial_ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.pixel && emit) begin
			pixel_x <= rsd_pkg::COORD_W'(column_q);
			pixel_y <= rsd_pkg::COORD_W'(row_q);
			argb    <= rsd_pkg::expand(color, rtt_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/rle_sprite_pixel_decoder_core.sv =====
// Top level of the run-length coded sprite pixel decoder.
//
// byte_ch takes one byte of the coded stream per transfer; image_start on a
// byte clears position and parser before that byte is decoded as a command.
// pixel_ch gives one transfer per visible pixel: column, row and ARGB32 color.
// cfg writes image_width (index 0), image_height (1) and red_to_transparent
// (2); it is always ready and must only be used while the block is idle.
// Command, count and low color bytes never wait for the output register. A pixel appears on
// pixel_ch in the cycle after its high byte transfers. A skip count byte starts
// the one-bit-per-cycle restoring divider that wraps the column over the rows;
// it steps in ST_DIV, writes back in ST_FINISH, and byte_ch is not ready meanwhile.
// The pixel output register holds a result until taken; while it stalls,
// bytes still transfer unless the parser awaits a high color byte.
// Reset sets width and height to 1024 (clamped to the maximum), red mode off,
// and the parser to await a command byte at column 0, row 0.
`default_nettype none

module rle_sprite_pixel_decoder_core #(
	parameter int MAX_WIDTH  = rsd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rsd_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rsd_byte_if.sink     byte_ch,
	rsd_pixel_if.source  pixel_ch,
	rsd_cfg_if.sink      cfg
);

	localparam int POS_W = $clog2(MAX_WIDTH + 255);

	rsd_pkg::cmd_t    cmd;
	rsd_pkg::status_t status;

	assign cfg.ready = 1'b1;

	rsd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (byte_ch.valid),
		.in_ready    (byte_ch.ready),
		.stream_byte (byte_ch.stream_byte),
		.image_start (byte_ch.image_start),
		.status      (status),
		.cmd         (cmd)
	);

	rsd_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.stream_byte (byte_ch.stream_byte),
		.cmd         (cmd),
		.out_ready   (pixel_ch.ready),
		.status      (status),
		.out_valid   (pixel_ch.valid),
		.pixel_x     (pixel_ch.pixel_x),
		.pixel_y     (pixel_ch.pixel_y),
		.argb        (pixel_ch.argb)
	);

`ifndef SYNTHESIS
	a_pixel_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pixel |-> !status.out_stall)
		else $error("pixel decoded while output register stalled");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> ##(POS_W + 1) cmd.div_finish)
		else $error("skip division did not finish on time");

	a_no_transfer_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.div_finish) |-> !byte_ch.ready)
		else $error("byte channel ready during skip division");
`endif

endmodule

`default_nettype wire
